/* sv/btss_pkg.sv */
`default_nettype none
package btss_pkg;

    localparam logic [2:0] KIND_CLEAR  = 3'd0;
    localparam logic [2:0] KIND_LOAD   = 3'd1;
    localparam logic [2:0] KIND_SAMPLE = 3'd2;
    localparam logic [2:0] KIND_CDF    = 3'd3;
    localparam logic [2:0] KIND_PMF    = 3'd4;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_DUP   = 3'd1;
    localparam logic [2:0] ST_FULL  = 3'd2;
    localparam logic [2:0] ST_EMPTY = 3'd3;
    localparam logic [2:0] ST_ZERO  = 3'd4;

    localparam logic signed [39:0] LOG2E_Q16 = 40'sd94548;
    localparam logic signed [28:0] T_LO = -29'sd268435456;
    localparam logic signed [28:0] T_HI = 29'sd201326592;
    localparam logic [39:0] PREFIX_MAX = 40'hFF_FFFF_FFFF;

    typedef enum logic [2:0] {
        OP_CLEAR,
        OP_LOAD,
        OP_SAMPLE,
        OP_CDF,
        OP_PMF,
        OP_NONE
    } op_t;

    typedef struct packed {
        op_t                op;
        logic signed [31:0] x_value;
        logic signed [31:0] energy;
        logic [31:0]        random_fraction;
    } item_t;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] sampled_x;
        logic [7:0]         sampled_index;
        logic [31:0]        point_weight;
        logic [39:0]        cumulative_weight;
        logic signed [31:0] smallest_x;
        logic signed [31:0] largest_x;
        logic [8:0]         point_count;
    } result_t;

endpackage
`default_nettype wire

/* sv/btss_front.sv */
`default_nettype none
module btss_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [2:0]    in_kind,
    input  wire logic [31:0]   in_x,
    input  wire logic [31:0]   in_energy,
    input  wire logic [31:0]   in_random,
    output logic               q_valid,
    input  wire logic          q_ready,
    output btss_pkg::item_t    q_item
);
    import btss_pkg::*;

    item_t      q_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    item_t      dec;
    logic       push;
    logic       pop;

    always_comb
    begin
        dec.x_value         = in_x;
        dec.energy          = in_energy;
        dec.random_fraction = in_random;
        case (in_kind)
            KIND_CLEAR:  dec.op = OP_CLEAR;
            KIND_LOAD:   dec.op = OP_LOAD;
            KIND_SAMPLE: dec.op = OP_SAMPLE;
            KIND_CDF:    dec.op = OP_CDF;
            KIND_PMF:    dec.op = OP_PMF;
            default:     dec.op = OP_NONE;
        endcase
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = q_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule
`default_nettype wire

/* sv/btss_back.sv */
`default_nettype none
module btss_back #(
    parameter int DEPTH = 256
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_wen,
    input  wire logic [15:0]    cfg_wdata,
    input  wire logic           q_valid,
    output logic                q_ready,
    input  wire btss_pkg::item_t q_item,
    output logic                out_valid,
    input  wire logic           out_ready,
    output btss_pkg::result_t   out_result
);
    import btss_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    typedef enum logic [4:0] {
        S_IDLE, S_SRCH, S_CMP, S_FIN, S_POSTRD, S_W1, S_W2, S_W3, S_W4, S_W5, S_W6,
        S_SH_RD, S_SH_WR, S_INS, S_RB_RD, S_RB_WR, S_DISP, S_TOT_RD, S_TOT,
        S_T1, S_T2, S_XRD, S_OUT
    } state_t;

    logic signed [31:0] x_mem [DEPTH];
    logic [31:0]        w_mem [DEPTH];
    logic [39:0]        p_mem [DEPTH];
    logic signed [31:0] x_rdata_reg;
    logic [31:0]        w_rdata_reg;
    logic [39:0]        p_rdata_reg;

    state_t             state_reg;
    item_t              cur_reg;
    result_t            res_reg;
    result_t            out_reg;
    logic               out_valid_reg;
    logic signed [15:0] beta_reg;
    logic [CW-1:0]      count_reg;
    logic               stale_reg;
    logic signed [31:0] min_reg;
    logic signed [31:0] max_reg;
    logic [CW-1:0]      a_reg;
    logic [CW-1:0]      b_reg;
    logic [CW-1:0]      mid_reg;
    logic [CW-1:0]      idx_reg;
    logic               sel_p_reg;
    logic               hit_reg;
    logic signed [47:0] prod_reg;
    logic signed [23:0] u_reg;
    logic [16:0]        acc_reg;
    logic [17:0]        m_reg;
    logic [31:0]        w_reg;
    logic [39:0]        run_reg;
    logic [39:0]        total_reg;
    logic [63:0]        m1_reg;
    logic [39:0]        target_reg;

    logic [CW-1:0]      mid;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic               xw_we;
    logic               p_we;
    logic signed [31:0] x_wdata;
    logic [31:0]        w_wdata;
    logic signed [48:0] t_full;
    logic signed [28:0] t_clamp;
    logic signed [21:0] tq;
    logic signed [39:0] prod2;
    logic signed [7:0]  k_exp;
    logic [15:0]        frac;
    logic [31:0]        mul16;
    logic [63:0]        shl;
    logic [5:0]         shr_amt;
    logic [31:0]        w_calc;
    logic [40:0]        run_sum;
    logic [39:0]        run_next;
    logic               go_right;
    logic [CW-1:0]      a_fix;

    assign mid      = a_reg + ((b_reg - a_reg) >> 1);
    assign k_exp    = u_reg[23:16];
    assign frac     = u_reg[15:0];
    assign run_sum  = {1'b0, run_reg} + {9'd0, w_rdata_reg};
    assign run_next = run_sum[40] ? PREFIX_MAX : run_sum[39:0];
    assign go_right = sel_p_reg ? !(p_rdata_reg > target_reg) : !(x_rdata_reg > cur_reg.x_value);
    assign a_fix    = (a_reg >= count_reg) ? count_reg - 1'b1 : a_reg;

    always_comb
    begin
        t_full  = -{prod_reg[47], prod_reg};
        if (t_full < 49'(T_LO))
        begin
            t_clamp = T_LO;
        end
        else if (t_full > 49'(T_HI))
        begin
            t_clamp = T_HI;
        end
        else
        begin
            t_clamp = t_full[28:0];
        end
        tq    = 22'(t_clamp >>> 8);
        prod2 = 40'(tq) * LOG2E_Q16;
    end

    always_comb
    begin
        case (state_reg)
            S_W3:    mul16 = 32'd5184 * {16'd0, frac};
            S_W4:    mul16 = {15'd0, acc_reg} * {16'd0, frac};
            default: mul16 = {15'd0, acc_reg} * {16'd0, frac};
        endcase
    end

    always_comb
    begin
        shl     = {46'd0, m_reg} << k_exp[4:0];
        shr_amt = 6'(-k_exp);
        if (k_exp > 8'sd20)
        begin
            w_calc = 32'hFFFF_FFFF;
        end
        else if (!k_exp[7])
        begin
            w_calc = (shl[63:32] != 32'd0) ? 32'hFFFF_FFFF : shl[31:0];
        end
        else if (k_exp < -8'sd40)
        begin
            w_calc = 32'd0;
        end
        else
        begin
            w_calc = 32'({14'd0, m_reg} >> shr_amt);
        end
    end

    always_comb
    begin
        rd_addr = mid[AW-1:0];
        wr_addr = idx_reg[AW-1:0];
        xw_we   = 1'b0;
        p_we    = 1'b0;
        x_wdata = x_rdata_reg;
        w_wdata = w_rdata_reg;
        case (state_reg)
            S_SRCH:
            begin
                if (a_reg < b_reg)
                begin
                    rd_addr = mid[AW-1:0];
                end
                else if (sel_p_reg)
                begin
                    rd_addr = a_fix[AW-1:0];
                end
                else
                begin
                    rd_addr = AW'(a_reg - 1'b1);
                end
            end
            S_FIN:    rd_addr = AW'(a_reg - 1'b1);
            S_SH_RD:  rd_addr = AW'(idx_reg - 1'b1);
            S_SH_WR:  xw_we = 1'b1;
            S_INS:
            begin
                xw_we   = 1'b1;
                wr_addr = a_reg[AW-1:0];
                x_wdata = cur_reg.x_value;
                w_wdata = w_reg;
            end
            S_RB_RD:  rd_addr = idx_reg[AW-1:0];
            S_RB_WR:  p_we = 1'b1;
            S_TOT_RD: rd_addr = AW'(count_reg - 1'b1);
            default:  rd_addr = mid[AW-1:0];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (xw_we)
        begin
            x_mem[wr_addr] <= x_wdata;
            w_mem[wr_addr] <= w_wdata;
        end
        if (p_we)
        begin
            p_mem[wr_addr] <= run_next;
        end
        x_rdata_reg <= x_mem[rd_addr];
        w_rdata_reg <= w_mem[rd_addr];
        p_rdata_reg <= p_mem[rd_addr];
    end

    assign q_ready    = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            beta_reg      <= 16'sd256;
            count_reg     <= '0;
            stale_reg     <= 1'b1;
        end
        else
        begin
            if (cfg_wen)
            begin
                beta_reg <= cfg_wdata;
            end
            if (out_valid_reg && out_ready && state_reg != S_OUT)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        cur_reg   <= q_item;
                        a_reg     <= '0;
                        b_reg     <= count_reg;
                        sel_p_reg <= 1'b0;
                        hit_reg   <= 1'b0;
                        idx_reg   <= '0;
                        run_reg   <= '0;
                        case (q_item.op)
                            OP_CLEAR:
                            begin
                                res_reg   <= '0;
                                count_reg <= '0;
                                stale_reg <= 1'b1;
                                state_reg <= S_OUT;
                            end
                            OP_LOAD:
                            begin
                                res_reg   <= '0;
                                state_reg <= S_SRCH;
                            end
                            OP_SAMPLE, OP_CDF, OP_PMF:
                            begin
                                if (count_reg == '0)
                                begin
                                    res_reg   <= {ST_EMPTY, 185'd0};
                                    state_reg <= S_OUT;
                                end
                                else if (stale_reg)
                                begin
                                    res_reg   <= '0;
                                    state_reg <= S_RB_RD;
                                end
                                else
                                begin
                                    res_reg   <= '0;
                                    state_reg <= S_DISP;
                                end
                            end
                            default:
                            begin
                                res_reg   <= '0;
                                state_reg <= S_OUT;
                            end
                        endcase
                    end
                end
                S_RB_RD: state_reg <= S_RB_WR;
                S_RB_WR:
                begin
                    run_reg <= run_next;
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg + 1'b1 >= count_reg)
                    begin
                        stale_reg <= 1'b0;
                        state_reg <= S_DISP;
                    end
                    else
                    begin
                        state_reg <= S_RB_RD;
                    end
                end
                S_DISP:
                begin
                    if (cur_reg.op == OP_SAMPLE)
                    begin
                        state_reg <= S_TOT_RD;
                    end
                    else
                    begin
                        state_reg <= S_SRCH;
                    end
                end
                S_TOT_RD: state_reg <= S_TOT;
                S_TOT:
                begin
                    total_reg <= p_rdata_reg;
                    if (p_rdata_reg == 40'd0)
                    begin
                        res_reg.status <= ST_ZERO;
                        state_reg      <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_T1;
                    end
                end
                S_T1:
                begin
                    m1_reg    <= {32'd0, cur_reg.random_fraction} * {32'd0, total_reg[31:0]};
                    state_reg <= S_T2;
                end
                S_T2:
                begin
                    target_reg <= ({8'd0, cur_reg.random_fraction} * {32'd0, total_reg[39:32]})
                                  + {8'd0, m1_reg[63:32]};
                    sel_p_reg  <= 1'b1;
                    state_reg  <= S_SRCH;
                end
                S_SRCH:
                begin
                    if (a_reg < b_reg)
                    begin
                        mid_reg   <= mid;
                        state_reg <= S_CMP;
                    end
                    else
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_CMP:
                begin
                    if (go_right)
                    begin
                        a_reg <= mid_reg + 1'b1;
                    end
                    else
                    begin
                        b_reg <= mid_reg;
                    end
                    if (!sel_p_reg && x_rdata_reg == cur_reg.x_value)
                    begin
                        hit_reg <= 1'b1;
                    end
                    state_reg <= S_SRCH;
                end
                S_FIN:
                begin
                    case (cur_reg.op)
                        OP_LOAD:
                        begin
                            if (hit_reg)
                            begin
                                res_reg.status <= ST_DUP;
                                state_reg      <= S_OUT;
                            end
                            else if (count_reg >= DEPTH_C)
                            begin
                                res_reg.status <= ST_FULL;
                                state_reg      <= S_OUT;
                            end
                            else
                            begin
                                state_reg <= S_W1;
                            end
                        end
                        OP_SAMPLE:
                        begin
                            {res_reg.sampled_x, res_reg.sampled_index} <=
                                {x_rdata_reg, 8'(a_fix)};
                            state_reg <= S_OUT;
                        end
                        default:
                        begin
                            if (a_reg == '0)
                            begin
                                state_reg <= S_OUT;
                            end
                            else
                            begin
                                state_reg <= S_POSTRD;
                            end
                        end
                    endcase
                end
                S_POSTRD:
                begin
                    if (cur_reg.op == OP_CDF)
                    begin
                        res_reg.cumulative_weight <= p_rdata_reg;
                    end
                    else if (hit_reg)
                    begin
                        res_reg.point_weight <= w_rdata_reg;
                    end
                    state_reg <= S_OUT;
                end
                S_W1:
                begin
                    prod_reg  <= beta_reg * cur_reg.energy;
                    state_reg <= S_W2;
                end
                S_W2:
                begin
                    u_reg     <= 24'(prod2 >>> 16);
                    state_reg <= S_W3;
                end
                S_W3:
                begin
                    acc_reg   <= 17'(32'd14752 + (mul16 >> 16));
                    state_reg <= S_W4;
                end
                S_W4:
                begin
                    acc_reg   <= 17'(32'd45600 + (mul16 >> 16));
                    state_reg <= S_W5;
                end
                S_W5:
                begin
                    m_reg     <= 18'(32'd65536 + (mul16 >> 16));
                    state_reg <= S_W6;
                end
                S_W6:
                begin
                    w_reg     <= w_calc;
                    idx_reg   <= count_reg;
                    state_reg <= S_SH_RD;
                end
                S_SH_RD:
                begin
                    if (idx_reg > a_reg)
                    begin
                        state_reg <= S_SH_WR;
                    end
                    else
                    begin
                        state_reg <= S_INS;
                    end
                end
                S_SH_WR:
                begin
                    idx_reg   <= idx_reg - 1'b1;
                    state_reg <= S_SH_RD;
                end
                S_INS:
                begin
                    if (a_reg == '0)
                    begin
                        min_reg <= cur_reg.x_value;
                    end
                    if (a_reg == count_reg)
                    begin
                        max_reg <= cur_reg.x_value;
                    end
                    count_reg <= count_reg + 1'b1;
                    stale_reg <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_reg       <= {res_reg.status, res_reg.sampled_x,
                                          res_reg.sampled_index, res_reg.point_weight,
                                          res_reg.cumulative_weight,
                                          (count_reg != '0) ? min_reg : 32'sd0,
                                          (count_reg != '0) ? max_reg : 32'sd0,
                                          9'(count_reg)};
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("Entry count exceeds table depth.");

    a_search_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> (a_reg <= mid_reg && mid_reg < b_reg))
        else $error("Search probe lies outside its interval.");

    a_rebuild_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RB_RD) |-> (idx_reg < count_reg))
        else $error("Prefix rebuild walks past the last entry.");

    a_shift_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SH_WR) |-> (idx_reg < DEPTH_C && idx_reg > a_reg))
        else $error("Insert shift writes outside the table.");

endmodule
`default_nettype wire

/* sv/boltzmann_table_sampler_core.sv */
`default_nettype none
// Sorted table of up to DEPTH weighted points with load, clear, sample, cdf and pmf items.
// Each item gives one result. A load runs a binary search, the weight pipeline and
// the one-port insert shift of the entries after the insert point. Sample, cdf and
// pmf run a binary search, first rebuilding the prefix sums entry by entry when a
// load or clear has made them stale. A two-item queue ahead of the sequencer and a
// result register behind it let either side stall on its own.
module boltzmann_table_sampler_core #(
    parameter int DEPTH = 256
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_wen,
    input  wire logic [15:0]  cfg_wdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // x_value[31:0], energy[63:32], random_fraction[95:64]
    input  wire logic [95:0]  s_tdata,
    // kind[2:0]
    input  wire logic [2:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // sampled_x[31:0], sampled_index[39:32], point_weight[71:40],
    // cumulative_weight[111:72], smallest_x[143:112], largest_x[175:144],
    // point_count[184:176], zero fill[191:185]
    output logic [191:0]      m_tdata,
    // status[2:0]
    output logic [2:0]        m_tuser
);
    import btss_pkg::*;

    item_t   q_item;
    logic    q_valid;
    logic    q_ready;
    result_t res;

    btss_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (s_tuser),
        .in_x      (s_tdata[31:0]),
        .in_energy (s_tdata[63:32]),
        .in_random (s_tdata[95:64]),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item)
    );

    btss_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wen    (cfg_wen),
        .cfg_wdata  (cfg_wdata),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_item     (q_item),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (res)
    );

    assign m_tuser = res.status;
    assign m_tdata = {7'd0, res.point_count, res.largest_x, res.smallest_x,
                      res.cumulative_weight, res.point_weight, res.sampled_index,
                      res.sampled_x};

endmodule
`default_nettype wire
